### rtl/qsd_pkg.sv
package qsd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_KEY      = 2'd0;
    localparam logic [1:0] KIND_VALUE    = 2'd1;
    localparam logic [1:0] KIND_END_KEY  = 2'd2;
    localparam logic [1:0] KIND_END_PAIR = 2'd3;

    // Input actions
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Special characters
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] HEX_ALPHA  = 8'd10;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_KEY    = 3'd1,
        MODE_VALUE  = 3'd2,
        MODE_KEYESC = 3'd3,
        MODE_VALESC = 3'd4
    } mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } qsd_res_t;

    // Up to two results produced by one request
    typedef struct packed {
        logic [1:0] count;
        qsd_res_t   r1;
        qsd_res_t   r0;
    } qsd_pair_t;

    typedef struct packed {
        mode_t      mode;
        logic       seen;
    } qsd_stat_t;

endpackage

### rtl/qsd_decode.sv
module qsd_decode
    import qsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic       action,
    input  logic [7:0] char_byte,
    output qsd_pair_t  pair,
    output qsd_stat_t  stat
);

    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [7:0] data;
        mode_t      mode;
    } step_t;

    mode_t      mode_reg, mode_next;
    logic       seen_reg, seen_next;
    logic [3:0] nib_reg, nib_next;

    // Returns {is_hex, value}
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= "0" && ch <= "9") begin
            r = {1'b1, 4'(ch - "0")};
        end else if (ch >= "a" && ch <= "f") begin
            r = {1'b1, 4'(ch - "a" + HEX_ALPHA)};
        end else if (ch >= "A" && ch <= "F") begin
            r = {1'b1, 4'(ch - "A" + HEX_ALPHA)};
        end
        return r;
    endfunction

    // Handle one byte outside an escape
    function automatic step_t plain_byte(input mode_t m, input logic [7:0] ch);
        step_t s;
        s.emit = 1'b0;
        s.kind = KIND_KEY;
        s.data = 8'd0;
        s.mode = m;
        case (m)
            MODE_KEY: begin
                if (ch == CH_EQUAL) begin
                    s.mode = MODE_VALUE;
                end else if (ch == CH_AMP) begin
                    s.emit = 1'b1;
                    s.kind = KIND_END_KEY;
                    s.mode = MODE_IDLE;
                end else if (ch == CH_PERCENT) begin
                    s.mode = MODE_KEYESC;
                end else begin
                    s.emit = 1'b1;
                    s.data = ch;
                end
            end
            MODE_VALUE: begin
                s.kind = KIND_VALUE;
                if (ch == CH_PERCENT) begin
                    s.mode = MODE_VALESC;
                end else if (ch == CH_AMP) begin
                    s.emit = 1'b1;
                    s.kind = KIND_END_PAIR;
                    s.mode = MODE_IDLE;
                end else if (ch == CH_PLUS) begin
                    s.emit = 1'b1;
                    s.data = CH_SPACE;
                end else begin
                    s.emit = 1'b1;
                    s.data = ch;
                end
            end
            default: begin
                if (ch == CH_EQUAL) begin
                    s.mode = MODE_VALUE;
                end else if (ch == CH_AMP) begin
                    s.mode = MODE_IDLE;
                end else if (ch == CH_PERCENT) begin
                    s.mode = MODE_KEYESC;
                end else begin
                    s.emit = 1'b1;
                    s.data = ch;
                    s.mode = MODE_KEY;
                end
            end
        endcase
        return s;
    endfunction

    logic       esc;
    logic       esc_key;
    logic [4:0] hexv;
    logic [1:0] esc_kind;
    logic [7:0] flush_byte;
    mode_t      flush_mode;
    step_t      st;

    assign esc        = (mode_reg == MODE_KEYESC) || (mode_reg == MODE_VALESC);
    assign esc_key    = (mode_reg == MODE_KEYESC);
    assign hexv       = hex_value(char_byte);
    assign esc_kind   = esc_key ? KIND_KEY : KIND_VALUE;
    assign flush_byte = seen_reg ? {4'd0, nib_reg} : CH_PERCENT;
    assign flush_mode = esc_key ? MODE_KEY : MODE_VALUE;
    assign st         = plain_byte(esc ? flush_mode : mode_reg, char_byte);

    // Work out the results and the next parse state
    always_comb begin
        pair       = '0;
        mode_next  = mode_reg;
        seen_next  = seen_reg;
        nib_next   = nib_reg;
        if (action == ACT_END) begin
            mode_next = MODE_IDLE;
            seen_next = 1'b0;
            nib_next  = 4'd0;
            if (esc) begin
                pair.count   = 2'd2;
                pair.r0.kind = esc_kind;
                pair.r0.data = flush_byte;
                pair.r1.kind = esc_key ? KIND_END_KEY : KIND_END_PAIR;
            end else if (mode_reg == MODE_KEY) begin
                pair.count   = 2'd1;
                pair.r0.kind = KIND_END_KEY;
            end else if (mode_reg == MODE_VALUE) begin
                pair.count   = 2'd1;
                pair.r0.kind = KIND_END_PAIR;
            end
        end else if (esc) begin
            if (hexv[4] && seen_reg) begin
                pair.count   = 2'd1;
                pair.r0.kind = esc_kind;
                pair.r0.data = {nib_reg, hexv[3:0]};
                mode_next    = flush_mode;
                seen_next    = 1'b0;
                nib_next     = 4'd0;
            end else if (hexv[4]) begin
                seen_next = 1'b1;
                nib_next  = hexv[3:0];
            end else begin
                pair.count   = st.emit ? 2'd2 : 2'd1;
                pair.r0.kind = esc_kind;
                pair.r0.data = flush_byte;
                pair.r1.kind = st.kind;
                pair.r1.data = st.data;
                mode_next    = st.mode;
                seen_next    = 1'b0;
                nib_next     = 4'd0;
            end
        end else begin
            pair.count   = st.emit ? 2'd1 : 2'd0;
            pair.r0.kind = st.kind;
            pair.r0.data = st.data;
            mode_next    = st.mode;
        end
        // Mark the final result of this request
        pair.r0.last = (pair.count == 2'd1);
        pair.r1.last = (pair.count == 2'd2);
    end

    // Hold the parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            seen_reg <= 1'b0;
            nib_reg  <= 4'd0;
        end else if (advance) begin
            mode_reg <= mode_next;
            seen_reg <= seen_next;
            nib_reg  <= nib_next;
        end
    end

    assign stat.mode = mode_reg;
    assign stat.seen = seen_reg;

endmodule

### rtl/qsd_res_queue.sv
module qsd_res_queue
    import qsd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  qsd_pair_t       wr_pair,
    output logic            room,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [15:0]     m_axis_tdata,   // [1:0] out_kind, [9:2] out_byte, [15:10] zero
    output logic            m_axis_tlast    // last_of_run
);

    qsd_res_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]     fill_reg, fill_next;
    logic [QCNT_W-1:0]     wr_num;
    logic                  rd_en;
    logic [QPTR_W-1:0]     wr_ptr_p1;

    assign wr_num    = wr_en ? QCNT_W'(wr_pair.count) : '0;
    assign rd_en     = m_axis_tvalid && m_axis_tready;
    assign fill_next = fill_reg + wr_num - QCNT_W'(rd_en);
    assign wr_ptr_p1 = wr_ptr_reg + QPTR_W'(1);
    // Two free entries cover the largest burst of one request
    assign room      = (fill_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // Store results
    always_ff @(posedge aclk) begin
        if (wr_en && wr_pair.count != 2'd0) begin
            mem[wr_ptr_reg] <= wr_pair.r0;
        end
        if (wr_en && wr_pair.count == 2'd2) begin
            mem[wr_ptr_p1] <= wr_pair.r1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(wr_num);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(rd_en);
            fill_reg   <= fill_next;
        end
    end

    assign m_axis_tvalid = (fill_reg != '0);
    assign m_axis_tdata  = {6'd0, mem[rd_ptr_reg].data, mem[rd_ptr_reg].kind};
    assign m_axis_tlast  = mem[rd_ptr_reg].last;

endmodule

### rtl/query_string_decoder.sv
// Query string decoder.
// Input stream: one request per string byte (tuser = 0, tdata = byte) and a
// closing request with tuser = 1 that flushes any open escape and parameter.
// Output stream: tagged results; tdata carries the kind (key byte, value byte,
// end of key-only parameter, end of key-value parameter) and the decoded byte,
// tlast marks the final result caused by one input request.
// Path: a request is registered at the input, decoded combinationally from that
// register and written into a four-entry result queue, which offers its results
// on the output port once they are written.
// Throughput: one request per cycle while requests make at most one result and
// the receiver keeps tready high; the output port drains one result per cycle,
// so requests that make two results (escape flushes, end with an open escape)
// fill the queue faster than it drains. The queue accepts a decode only with two free entries.
// Reset: the parser returns to idle between parameters and the queue empties.
// Stall: when the receiver holds tready low the queue fills, decoding stops
// and s_axis_tready falls once the input register is occupied.
module query_string_decoder
    import qsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] out_kind, [9:2] out_byte, [15:10] zero
    output logic        m_axis_tlast    // last_of_run
);

    logic       in_valid_reg;
    logic       in_action_reg;
    logic [7:0] in_char_reg;
    logic       room;
    logic       advance;
    qsd_pair_t  pair;
    qsd_stat_t  stat;

    assign advance       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_action_reg <= s_axis_tuser;
            in_char_reg   <= s_axis_tdata;
        end
    end

    qsd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .action    (in_action_reg),
        .char_byte (in_char_reg),
        .pair      (pair),
        .stat      (stat)
    );

    qsd_res_queue u_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wr_en         (advance),
        .wr_pair       (pair),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // An end request leaves the parser idle with no pending digit
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_action_reg == ACT_END |=> stat.mode == MODE_IDLE && !stat.seen)
        else $error("parser not idle after end request");

    // A pending digit only exists inside an escape
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.seen |-> stat.mode == MODE_KEYESC || stat.mode == MODE_VALESC)
        else $error("hex digit pending outside escape");

    // Two results carry the run mark only on the second
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && pair.count == 2'd2 |-> pair.r1.last && !pair.r0.last)
        else $error("run mark misplaced");

    // No request makes more than two results
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> pair.count != 2'd3)
        else $error("too many results for one request");

endmodule
